// ----- src/iprt_pkg.sv -----
// Shared types and codes for the IPv4 route table with longest-prefix match.
// Used by iprt_cell and ipv4_route_table_lpm; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package iprt_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DEL    = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_INVALID   = 3'd1,
        STS_EXISTS    = 3'd2,
        STS_FULL      = 3'd3,
        STS_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } fsm_t;

    localparam int ADDR_W = 32;
    localparam int IDX_IN_W = 4;

    // Request fields carried down the chain of cells.
    typedef struct packed {
        cmd_t                cmd;
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   gateway;
        logic [IDX_IN_W-1:0] slot_index;
    } req_t;

    // Flags gathered while a request walks past the cells.
    typedef struct packed {
        logic valid;
        logic dup;
        logic free_found;
        logic found;
    } scan_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic clr_en;
    } commit_t;

endpackage

`default_nettype wire

// ----- src/iprt_cell.sv -----
// One route slot of the table and the comparison logic for a passing request.
// Depends on iprt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iprt_cell
    import iprt_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int SLOT_W   = 4,
    parameter int CNT_W    = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  req_t              in_req,
    input  scan_t             in_scan,
    input  logic [SLOT_W-1:0] in_free_slot,
    input  logic [SLOT_W-1:0] in_hit_slot,
    input  entry_t            in_hit,
    input  logic [CNT_W-1:0]  in_count,
    output req_t              out_req,
    output scan_t             out_scan,
    output logic [SLOT_W-1:0] out_free_slot,
    output logic [SLOT_W-1:0] out_hit_slot,
    output entry_t            out_hit,
    output logic [CNT_W-1:0]  out_count,
    input  commit_t           commit,
    input  logic [SLOT_W-1:0] commit_slot,
    input  entry_t            commit_entry
);

    localparam int IDX_W = (SLOT_W > IDX_IN_W) ? SLOT_W : IDX_IN_W;
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0]  MY_IDX  = IDX_W'(CELL_IDX);

    logic   valid_reg;
    entry_t entry_reg;

    req_t              req_reg;
    scan_t             scan_reg, scan_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    entry_t            hit_reg, hit_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic exact;
    logic covers;
    logic idx_match;
    logic commit_here;

    assign exact = valid_reg && (entry_reg.dest == in_req.dest)
                   && (entry_reg.mask == in_req.mask);
    assign covers = valid_reg && ((in_req.dest & entry_reg.mask) == entry_reg.dest);
    assign idx_match = (IDX_W'(in_req.slot_index) == MY_IDX);
    assign commit_here = (commit_slot == MY_SLOT);

    // Stored masks are always contiguous, so a numerically larger mask is a
    // longer prefix. Strictly larger keeps the lowest slot on a tie.
    always_comb begin
        scan_next      = in_scan;
        free_slot_next = in_free_slot;
        hit_slot_next  = in_hit_slot;
        hit_next       = in_hit;
        count_next     = in_count + CNT_W'(valid_reg);
        unique case (in_req.cmd)
            CMD_ADD: begin
                if (exact) begin
                    scan_next.dup = 1'b1;
                end
                if (!valid_reg && !in_scan.free_found) begin
                    scan_next.free_found = 1'b1;
                    free_slot_next       = MY_SLOT;
                end
            end
            CMD_DEL: begin
                if (exact && !in_scan.found) begin
                    scan_next.found = 1'b1;
                    hit_slot_next   = MY_SLOT;
                end
            end
            CMD_LOOKUP: begin
                if (covers && (!in_scan.found || entry_reg.mask > in_hit.mask)) begin
                    scan_next.found = 1'b1;
                    hit_slot_next   = MY_SLOT;
                    hit_next        = entry_reg;
                end
            end
            CMD_READ: begin
                if (valid_reg && idx_match) begin
                    scan_next.found = 1'b1;
                    hit_slot_next   = MY_SLOT;
                    hit_next        = entry_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end else begin
            scan_reg <= scan_next;
            if (commit.wr_en && commit_here) begin
                valid_reg <= 1'b1;
            end else if (commit.clr_en && commit_here) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit.wr_en && commit_here) begin
            entry_reg <= commit_entry;
        end
        req_reg       <= in_req;
        free_slot_reg <= free_slot_next;
        hit_slot_reg  <= hit_slot_next;
        hit_reg       <= hit_next;
        count_reg     <= count_next;
    end

    assign out_req       = req_reg;
    assign out_scan      = scan_reg;
    assign out_free_slot = free_slot_reg;
    assign out_hit_slot  = hit_slot_reg;
    assign out_hit       = hit_reg;
    assign out_count     = count_reg;

endmodule

`default_nettype wire

// ----- src/ipv4_route_table_lpm.sv -----
// Top level of the IPv4 route table: stream ports, the chain of slot cells,
// result decision and output register. Depends on iprt_pkg and iprt_cell.
//
//   channel   ports                       direction  contents
//   request   s_tvalid s_tready s_tdata   in         command and its operands
//             s_tuser                                command code
//   result    m_tvalid m_tready m_tdata   out        status, matched entry, count
//             m_tuser                                status code
//
// A request walks the chain one cell per cycle; the chain output is captured in
// the done registers, and the result is then loaded into the output register
// when the output is free.
// One request is in flight at a time; the next is accepted once the previous
// result has been committed to the output register, even if it is not taken.
// A stalled result holds the finished request and the table update back.
// Reset clears the slot valid bits; stored routes are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_route_table_lpm
    import iprt_pkg::*;
#(
    parameter int NUM_ROUTES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dest_addr [31:0], net_mask [63:32], gateway [95:64], slot_index [99:96]
    input  logic [103:0] s_tdata,
    // cmd [1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_slot [3:0], entry_dest [35:4], entry_mask [67:36],
    // entry_gateway [99:68], valid_count [104:100]
    output logic [111:0] m_tdata,
    // status [2:0]
    output logic [2:0]   m_tuser
);

    localparam int SLOT_W = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
    localparam int CNT_W  = $clog2(NUM_ROUTES + 1);

    // Chain links: index k feeds cell k, index NUM_ROUTES leaves the last cell.
    req_t              req_link       [0:NUM_ROUTES];
    scan_t             scan_link      [0:NUM_ROUTES];
    logic [SLOT_W-1:0] free_slot_link [0:NUM_ROUTES];
    logic [SLOT_W-1:0] hit_slot_link  [0:NUM_ROUTES];
    entry_t            hit_link       [0:NUM_ROUTES];
    logic [CNT_W-1:0]  count_link     [0:NUM_ROUTES];

    commit_t           commit;
    logic [SLOT_W-1:0] commit_slot;
    entry_t            commit_entry;

    fsm_t state_reg, state_next;
    logic accept;
    logic capture;
    logic load;
    logic out_free;
    logic last_valid;

    req_t              done_req_reg;
    scan_t             done_scan_reg;
    logic [SLOT_W-1:0] done_free_slot_reg;
    logic [SLOT_W-1:0] done_hit_slot_reg;
    entry_t            done_hit_reg;
    logic [CNT_W-1:0]  done_count_reg;

    logic              m_valid_reg;
    status_t           m_status_reg, m_status_next;
    logic [3:0]        m_slot_reg, m_slot_next;
    entry_t            m_entry_reg, m_entry_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;

    logic [ADDR_W-1:0] mask_inv;
    logic              mask_ok;
    logic              add_ok;
    logic              del_ok;
    logic              show_hit;

    // Request enters cell 0 straight from the ports.
    assign req_link[0].cmd        = cmd_t'(s_tuser);
    assign req_link[0].dest       = s_tdata[31:0];
    assign req_link[0].mask       = s_tdata[63:32];
    assign req_link[0].gateway    = s_tdata[95:64];
    assign req_link[0].slot_index = s_tdata[99:96];
    assign scan_link[0]           = '{valid: accept, dup: 1'b0, free_found: 1'b0,
                                      found: 1'b0};
    assign free_slot_link[0]      = '0;
    assign hit_slot_link[0]       = '0;
    assign hit_link[0]            = '0;
    assign count_link[0]          = '0;

    for (genvar k = 0; k < NUM_ROUTES; k++) begin : g_cell
        iprt_cell #(
            .CELL_IDX (k),
            .SLOT_W   (SLOT_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .in_req        (req_link[k]),
            .in_scan       (scan_link[k]),
            .in_free_slot  (free_slot_link[k]),
            .in_hit_slot   (hit_slot_link[k]),
            .in_hit        (hit_link[k]),
            .in_count      (count_link[k]),
            .out_req       (req_link[k+1]),
            .out_scan      (scan_link[k+1]),
            .out_free_slot (free_slot_link[k+1]),
            .out_hit_slot  (hit_slot_link[k+1]),
            .out_hit       (hit_link[k+1]),
            .out_count     (count_link[k+1]),
            .commit        (commit),
            .commit_slot   (commit_slot),
            .commit_entry  (commit_entry)
        );
    end

    assign last_valid = scan_link[NUM_ROUTES].valid;
    assign out_free   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_SEARCH;
            S_SEARCH: if (last_valid) state_next = S_FINISH;
            S_FINISH: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        capture  = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            S_IDLE:   s_tready = 1'b1;
            S_SEARCH: capture  = last_valid;
            S_FINISH: load     = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            done_req_reg       <= req_link[NUM_ROUTES];
            done_scan_reg      <= scan_link[NUM_ROUTES];
            done_free_slot_reg <= free_slot_link[NUM_ROUTES];
            done_hit_slot_reg  <= hit_slot_link[NUM_ROUTES];
            done_hit_reg       <= hit_link[NUM_ROUTES];
            done_count_reg     <= count_link[NUM_ROUTES];
        end
    end

    // Mask valid when its complement is ones from bit 0 up and dest is 0 below.
    assign mask_inv = ~done_req_reg.mask;
    assign mask_ok  = ((mask_inv & (mask_inv + ADDR_W'(1))) == '0)
                      && ((done_req_reg.dest & mask_inv) == '0);

    always_comb begin
        m_status_next = STS_OK;
        add_ok        = 1'b0;
        del_ok        = 1'b0;
        show_hit      = 1'b0;
        unique case (done_req_reg.cmd) inside
            CMD_ADD: begin
                if (!mask_ok) begin
                    m_status_next = STS_INVALID;
                end else if (done_scan_reg.dup) begin
                    m_status_next = STS_EXISTS;
                end else if (!done_scan_reg.free_found) begin
                    m_status_next = STS_FULL;
                end else begin
                    add_ok = 1'b1;
                end
            end
            CMD_DEL: begin
                if (done_scan_reg.found) begin
                    del_ok = 1'b1;
                end else begin
                    m_status_next = STS_NOT_FOUND;
                end
            end
            CMD_LOOKUP, CMD_READ: begin
                if (done_scan_reg.found) begin
                    show_hit = 1'b1;
                end else begin
                    m_status_next = STS_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
        m_slot_next  = show_hit ? 4'(done_hit_slot_reg) : 4'd0;
        m_entry_next = show_hit ? done_hit_reg : '0;
        m_count_next = done_count_reg + CNT_W'(add_ok) - CNT_W'(del_ok);
    end

    assign commit.wr_en  = load && add_ok;
    assign commit.clr_en = load && del_ok;
    assign commit_slot   = add_ok ? done_free_slot_reg : done_hit_slot_reg;
    assign commit_entry  = '{dest: done_req_reg.dest, mask: done_req_reg.mask,
                             gateway: done_req_reg.gateway};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_status_reg <= m_status_next;
            m_slot_reg   <= m_slot_next;
            m_entry_reg  <= m_entry_next;
            m_count_reg  <= m_count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, 5'(m_count_reg), m_entry_reg.gateway, m_entry_reg.mask,
                       m_entry_reg.dest, m_slot_reg};

    // A request leaves the chain only while the controller waits for it.
    a_exit_in_search : assert property (@(posedge aclk) disable iff (!aresetn)
        last_valid |-> state_reg == S_SEARCH)
        else $error("request left the chain outside the search phase");

    // An accepted request closes the input until its result is committed.
    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input still open with a request in flight");

    // One command never both fills and frees a slot.
    a_single_update : assert property (@(posedge aclk) disable iff (!aresetn)
        !(commit.wr_en && commit.clr_en))
        else $error("add and delete committed together");

    // The reported count never exceeds the table size.
    a_count_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_count_reg <= CNT_W'(NUM_ROUTES))
        else $error("valid count beyond table size");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the IPv4 route table with longest-prefix match.
// Drives route commands over the request stream and checks every result against
// a predictor or an inline result. Depends on iprt_pkg and ipv4_route_table_lpm.
`timescale 1ns / 1ps

module testbench;
    import iprt_pkg::*;

    localparam int NUM_ROUTES     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_DIRECTED     = 24;
    localparam int N_PHASES       = 4;
    localparam int PHASE_ITEMS    = 200;

    typedef struct packed {
        status_t     status;
        logic [3:0]  hit_slot;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [4:0]  valid_count;
    } route_result_t;

    // A row with known_result set carries its result inline; the others go
    // through the predictor.
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [3:0]  slot_index;
        bit          known_result;
        status_t     status;
        logic [4:0]  valid_count;
    } directed_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int error_count = 0;

    // Predictor copy of the route table.
    bit          tbl_valid   [NUM_ROUTES];
    logic [31:0] tbl_dest    [NUM_ROUTES];
    logic [31:0] tbl_mask    [NUM_ROUTES];
    logic [31:0] tbl_gateway [NUM_ROUTES];

    route_result_t expected_results[$];

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{CMD_READ,   32'h0, 32'h0, 32'h0, 4'd0, 1'b1, STS_NOT_FOUND, 5'd0},
        '{CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 4'd0, 1'b1, STS_NOT_FOUND, 5'd0},
        '{CMD_DEL,    32'h0, 32'h0, 32'h0, 4'd0, 1'b1, STS_NOT_FOUND, 5'd0},
        '{CMD_ADD, 32'h0000_0000, 32'h00FF_0000, 32'h1, 4'd0, 1'b1, STS_INVALID, 5'd0},
        '{CMD_ADD, 32'h0A00_0001, 32'hFF00_0000, 32'h1, 4'd0, 1'b1, STS_INVALID, 5'd0},
        '{CMD_ADD, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0, 1'b1, STS_OK, 5'd1},
        '{CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'd15, 1'b1, STS_OK, 5'd2},
        '{CMD_ADD, 32'h0000_0000, 32'h0000_0000, 32'h1234, 4'd0, 1'b1, STS_EXISTS, 5'd2},
        '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_LOOKUP, 32'h0A02_0304, 32'h0, 32'h0, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_READ,   32'h0, 32'h0, 32'h0, 4'd15, 1'b0, STS_OK, 5'd0},
        '{CMD_READ,   32'h0, 32'h0, 32'h0, 4'd1, 1'b0, STS_OK, 5'd0},
        '{CMD_DEL,    32'h0, 32'h0, 32'h0, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_ADD, 32'h0000_0000, 32'h0000_0000, 32'h5, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_DEL, 32'h0A01_0000, 32'hFFFF_00FF, 32'h0, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'hAAAA_AAAA, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_LOOKUP, 32'h8000_0001, 32'h0, 32'h0, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'd0, 1'b0, STS_OK, 5'd0},
        '{CMD_READ,   32'h0, 32'h0, 32'h0, 4'd3, 1'b0, STS_OK, 5'd0}
    };

    ipv4_route_table_lpm #(
        .NUM_ROUTES(NUM_ROUTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit is_prefix_mask(logic [31:0] m);
        logic [31:0] inv;
        inv = ~m;
        return (inv & (inv + 32'd1)) == 32'd0;
    endfunction

    function automatic logic [31:0] prefix_to_mask(int len);
        return ~(32'hFFFF_FFFF >> len);
    endfunction

    function automatic int pick_valid_slot();
        int slots[$];
        for (int i = 0; i < NUM_ROUTES; i++) begin
            if (tbl_valid[i]) slots.push_back(i);
        end
        if (slots.size() == 0) return -1;
        return slots[$urandom_range(slots.size() - 1)];
    endfunction

    // Applies one command to the predictor table and returns its result.
    task automatic predict_route_cmd(input cmd_t c, input logic [31:0] d, m, g,
                                     input logic [3:0] idx, output route_result_t r);
        int hit;
        int exact;
        int free_slot;
        int longest_len;
        int n;
        hit = -1;
        exact = -1;
        free_slot = -1;
        longest_len = -1;
        r.status = STS_OK;
        for (int i = NUM_ROUTES - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_dest[i] == d && tbl_mask[i] == m) exact = i;
            if (!tbl_valid[i]) free_slot = i;
        end
        case (c)
            CMD_ADD: begin
                if (!is_prefix_mask(m) || (d & ~m) != 32'd0) begin
                    r.status = STS_INVALID;
                end else if (exact >= 0) begin
                    r.status = STS_EXISTS;
                end else if (free_slot < 0) begin
                    r.status = STS_FULL;
                end else begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_dest[free_slot] = d;
                    tbl_mask[free_slot] = m;
                    tbl_gateway[free_slot] = g;
                end
            end
            CMD_DEL: begin
                if (exact >= 0) tbl_valid[exact] = 1'b0;
                else r.status = STS_NOT_FOUND;
            end
            CMD_LOOKUP: begin
                for (int i = 0; i < NUM_ROUTES; i++) begin
                    if (tbl_valid[i] && (d & tbl_mask[i]) == tbl_dest[i]
                            && $countones(tbl_mask[i]) > longest_len) begin
                        longest_len = $countones(tbl_mask[i]);
                        hit = i;
                    end
                end
                if (hit < 0) r.status = STS_NOT_FOUND;
            end
            default: begin
                if (tbl_valid[idx]) hit = idx;
                else r.status = STS_NOT_FOUND;
            end
        endcase
        if (hit >= 0) begin
            r.hit_slot = hit[3:0];
            r.dest = tbl_dest[hit];
            r.mask = tbl_mask[hit];
            r.gateway = tbl_gateway[hit];
        end else begin
            r.hit_slot = '0;
            r.dest = '0;
            r.mask = '0;
            r.gateway = '0;
        end
        n = 0;
        for (int i = 0; i < NUM_ROUTES; i++) n += tbl_valid[i];
        r.valid_count = n[4:0];
    endtask

    // Builds one random request. Most are well formed and aimed at routes that
    // are in the table; shrink mode favors deletes so the count moves both ways.
    task automatic make_request(input bit shrink, output cmd_t c, output logic [31:0] d, m, g,
                                output logic [3:0] idx);
        int roll;
        int s;
        int len;
        int base_len;
        roll = $urandom_range(99);
        d = $urandom;
        m = $urandom;
        g = $urandom;
        idx = 4'($urandom_range(15));
        s = pick_valid_slot();
        if (roll < 8) begin
            c = cmd_t'($urandom_range(3));
        end else if (roll < (shrink ? 23 : 53)) begin
            c = CMD_ADD;
            case ($urandom_range(9))
                0: begin
                    // Prefix mask but a destination bit set below it.
                    len = $urandom_range(31);
                    m = prefix_to_mask(len);
                    d = (d & m) | (32'd1 << $urandom_range(31 - len));
                end
                1: begin
                    if (s >= 0) begin
                        d = tbl_dest[s];
                        m = tbl_mask[s];
                    end
                end
                2: ;
                default: begin
                    if (s >= 0 && $urandom_range(1)) begin
                        // Nest a prefix of equal or longer length under an existing route.
                        base_len = $countones(tbl_mask[s]);
                        len = $urandom_range(32, base_len);
                        m = prefix_to_mask(len);
                        d = (tbl_dest[s] ^ (d & ~tbl_mask[s])) & m;
                    end else begin
                        m = prefix_to_mask($urandom_range(32));
                        d = d & m;
                    end
                end
            endcase
        end else if (roll < 68) begin
            c = CMD_DEL;
            if (s >= 0 && $urandom_range(3) != 0) begin
                d = tbl_dest[s];
                m = tbl_mask[s];
            end
        end else if (roll < 90) begin
            c = CMD_LOOKUP;
            if (s >= 0 && $urandom_range(3) != 0) d = tbl_dest[s] | (d & ~tbl_mask[s]);
        end else begin
            c = CMD_READ;
        end
        if (shrink && roll >= 23 && roll < 53) begin
            c = CMD_DEL;
            if (s >= 0 && $urandom_range(3) != 0) begin
                d = tbl_dest[s];
                m = tbl_mask[s];
            end
        end
    endtask

    // Presents one request and returns once it has been accepted.
    task automatic issue_request(input cmd_t c, input logic [31:0] d, m, g,
                                 input logic [3:0] idx);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {4'b0, idx, g, m, d};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        route_result_t got;
        route_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tuser);
            got.hit_slot = m_tdata[3:0];
            got.dest = m_tdata[35:4];
            got.mask = m_tdata[67:36];
            got.gateway = m_tdata[99:68];
            got.valid_count = m_tdata[104:100];
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request outstanding, actual %h", $time, got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("hit_slot", 32'(want.hit_slot), 32'(got.hit_slot));
                check_field("entry_dest", want.dest, got.dest);
                check_field("entry_mask", want.mask, got.mask);
                check_field("entry_gateway", want.gateway, got.gateway);
                check_field("valid_count", 32'(want.valid_count), 32'(got.valid_count));
            end
        end
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int idle_by_phase[N_PHASES];
        int stall_by_phase[N_PHASES];
        directed_row_t row;
        route_result_t predicted;
        route_result_t typed;
        cmd_t c;
        logic [31:0] d;
        logic [31:0] m;
        logic [31:0] g;
        logic [3:0] idx;

        idle_by_phase = '{0, 80, 0, 30};
        stall_by_phase = '{0, 0, 80, 30};
        for (int i = 0; i < NUM_ROUTES; i++) tbl_valid[i] = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            issue_request(row.cmd, row.dest, row.mask, row.gateway, row.slot_index);
            predict_route_cmd(row.cmd, row.dest, row.mask, row.gateway, row.slot_index,
                              predicted);
            if (row.known_result) begin
                typed = '0;
                typed.status = row.status;
                typed.valid_count = row.valid_count;
                expected_results.push_back(typed);
            end else begin
                expected_results.push_back(predicted);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            sender_idle_pct = idle_by_phase[p];
            receiver_stall_pct = stall_by_phase[p];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                make_request((k / 50) % 2 == 1, c, d, m, g, idx);
                issue_request(c, d, m, g, idx);
                predict_route_cmd(c, d, m, g, idx, predicted);
                expected_results.push_back(predicted);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- ipv4_route_table_lpm.f -----
src/iprt_pkg.sv
src/iprt_cell.sv
src/ipv4_route_table_lpm.sv
sim/testbench.sv
